FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk_i and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked at every clock edge outside reset
`define ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

`endif

FILE: sv/scfm_pkg.sv
// ----------------------------------------------------------------------------
// scfm_pkg
// shared constants, types and helpers of the serial command frame matcher
// ----------------------------------------------------------------------------
package scfm_pkg;

  localparam int unsigned MAX_FIELD_CHARS = 9;

  localparam logic [7:0] CH_OPEN  = 8'h23;
  localparam logic [7:0] CH_CLOSE = 8'h2A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned WORD_LEN   = 6;
  localparam int unsigned WORD_IDX_W = $clog2(WORD_LEN);

  localparam logic [8*WORD_LEN-1:0] WORD_UNLOCK = "unlock";
  localparam logic [8*WORD_LEN-1:0] WORD_BEEPON = "beepon";

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CODE_UNLOCK  = 2'd0,
    CODE_BEEPON  = 2'd1,
    CODE_UNKNOWN = 2'd2
  } cmd_code_e;

  // match outcome of one closed frame
  typedef struct packed {
    logic unlock_hit;
    logic beepon_hit;
  } scfm_hit_t;

  // character of a fixed word, first character at index zero
  function automatic logic [7:0] word_char(logic [8*WORD_LEN-1:0] word,
                                           logic [WORD_IDX_W-1:0] idx);
    logic [7:0] ch;
    ch = word[8*(WORD_LEN-1-int'(idx)) +: 8];
    return ch;
  endfunction

endpackage

FILE: sv/scfm_front.sv
// ----------------------------------------------------------------------------
// scfm_front
// frame tracker: classifies each byte, keeps the running word match and
// pushes one match outcome per closed frame
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scfm_front #(
  parameter int unsigned MaxFieldChars = scfm_pkg::MAX_FIELD_CHARS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  input  logic [7:0]         byte_i,
  output logic               push_o,
  output scfm_pkg::scfm_hit_t push_data_o
);
  import scfm_pkg::*;

  localparam int unsigned CntW = $clog2(MaxFieldChars + 1);
  localparam logic [CntW-1:0] MaxLen = CntW'(MaxFieldChars);

  logic            in_frame_q, in_frame_d;
  logic            in_param_q, in_param_d;
  logic [CntW-1:0] cmd_len_q, cmd_len_d;
  logic [CntW-1:0] par_len_q, par_len_d;
  logic            unlock_ok_q, unlock_ok_d;
  logic            beepon_ok_q, beepon_ok_d;
  logic            close;
  logic            in_word;
  logic            len_is_word;
  logic            len_zero;
  logic [WORD_IDX_W-1:0] idx;

  assign in_word     = cmd_len_q < CntW'(WORD_LEN);
  assign len_is_word = cmd_len_q == CntW'(WORD_LEN);
  assign len_zero    = (cmd_len_q == '0) && (par_len_q == '0);
  assign idx         = cmd_len_q[WORD_IDX_W-1:0];

  assign close = byte_valid_i && in_frame_q && (byte_i != CH_OPEN) && (byte_i != CH_SPACE)
                 && ((byte_i == CH_CLOSE) || (cmd_len_q == CntW'(MaxFieldChars))
                     || (par_len_q == CntW'(MaxFieldChars)));

  always_comb begin
    in_frame_d  = in_frame_q;
    in_param_d  = in_param_q;
    cmd_len_d   = cmd_len_q;
    par_len_d   = par_len_q;
    unlock_ok_d = unlock_ok_q;
    beepon_ok_d = beepon_ok_q;
    if (byte_valid_i) begin
      if (byte_i == CH_OPEN) begin
        in_frame_d  = 1'b1;
        in_param_d  = 1'b0;
        cmd_len_d   = '0;
        par_len_d   = '0;
        unlock_ok_d = 1'b1;
        beepon_ok_d = 1'b1;
      end else if (!in_frame_q) begin
        in_frame_d = 1'b0;
      end else if (byte_i == CH_SPACE) begin
        in_param_d = 1'b1;
      end else if (close) begin
        in_frame_d = 1'b0;
        in_param_d = 1'b0;
        cmd_len_d  = '0;
        par_len_d  = '0;
      end else if (in_param_q) begin
        par_len_d = par_len_q + CntW'(1);
      end else begin
        if (in_word) begin
          unlock_ok_d = unlock_ok_q && (byte_i == word_char(WORD_UNLOCK, idx));
          beepon_ok_d = beepon_ok_q && (byte_i == word_char(WORD_BEEPON, idx));
        end
        cmd_len_d = cmd_len_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      in_param_q  <= 1'b0;
      cmd_len_q   <= '0;
      par_len_q   <= '0;
      unlock_ok_q <= 1'b1;
      beepon_ok_q <= 1'b1;
    end else begin
      in_frame_q  <= in_frame_d;
      in_param_q  <= in_param_d;
      cmd_len_q   <= cmd_len_d;
      par_len_q   <= par_len_d;
      unlock_ok_q <= unlock_ok_d;
      beepon_ok_q <= beepon_ok_d;
    end
  end

  assign push_o                 = close;
  assign push_data_o.unlock_hit = unlock_ok_q && len_is_word;
  assign push_data_o.beepon_hit = beepon_ok_q && len_is_word;

  `ASSERT_CLK(a_len_bound, (cmd_len_q <= MaxLen) && (par_len_q <= MaxLen), "length overrun")
  `ASSERT_IMP(a_idle_clear, !in_frame_q, len_zero && !in_param_q, "stale frame state")

endmodule

FILE: sv/scfm_queue.sv
// ----------------------------------------------------------------------------
// scfm_queue
// short fifo of match outcomes between frame tracker and result stage
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scfm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  scfm_pkg::scfm_hit_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output scfm_pkg::scfm_hit_t data_o
);
  import scfm_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  scfm_hit_t       entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = count_q == CntW'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  `ASSERT_IMP(a_no_overflow, push_i, !full_o, "push into a full queue")

endmodule

FILE: sv/scfm_back.sv
// ----------------------------------------------------------------------------
// scfm_back
// result stage: turns match outcomes into command codes in an output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scfm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  scfm_pkg::scfm_hit_t q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          out_code_o
);
  import scfm_pkg::*;

  logic      valid_q, valid_d;
  cmd_code_e code_q, code_d;
  logic      load;

  assign load    = q_valid_i && (!valid_q || out_ready_i);
  assign q_pop_o = load;

  always_comb begin
    if (q_data_i.unlock_hit) begin
      code_d = CODE_UNLOCK;
    end else if (q_data_i.beepon_hit) begin
      code_d = CODE_BEEPON;
    end else begin
      code_d = CODE_UNKNOWN;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q <= code_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_code_o  = code_q;

  `ASSERT_IMP(a_pop_on_room, $past(q_valid_i && !valid_q), valid_q, "result not loaded")

endmodule

FILE: sv/serial_command_frame_matcher.sv
// ----------------------------------------------------------------------------
// serial_command_frame_matcher
// picks '#'-opened command frames out of a byte stream and reports whether
// the command word is "unlock", "beepon" or unknown
// ----------------------------------------------------------------------------
// channel   dir  tdata bits            handshake
// s_*       in   [7:0] rx_byte         s_tvalid_i / s_tready_o
// m_*       out  [1:0] command_code    m_tvalid_o / m_tready_i
//
// one byte per cycle while s_tready_o is high; the frame tracker decides and
// updates in the cycle a byte is taken; codes pass queue and output register
// a two-entry queue and the output register decouple the tracker from m_*;
// s_tready_o drops only while that queue is full
// rst_ni clears frame state, queue and output valid at once
// ----------------------------------------------------------------------------
module serial_command_frame_matcher #(
  parameter int unsigned MaxFieldChars = scfm_pkg::MAX_FIELD_CHARS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,   // [7:0] rx_byte
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o    // [1:0] command_code, [7:2] zero
);
  import scfm_pkg::*;

  logic      accept;
  logic      push;
  scfm_hit_t push_data;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  scfm_hit_t q_data;
  logic [1:0] code;

  assign s_tready_o = !q_full;
  assign accept     = s_tvalid_i && s_tready_o;

  scfm_front #(
    .MaxFieldChars(MaxFieldChars)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(accept),
    .byte_i      (s_tdata_i),
    .push_o      (push),
    .push_data_o (push_data)
  );

  scfm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .data_o     (q_data)
  );

  scfm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .out_valid_o(m_tvalid_o),
    .out_ready_i(m_tready_i),
    .out_code_o (code)
  );

  assign m_tdata_o = {6'b0, code};

endmodule
